>>> rtl/core/gamepad_state_table_with_deadzone_core_assert.svh
// Assertion helpers for the controller slot table core.
// Both expect clk and rst_n in the enclosing scope.
`ifndef GAMEPAD_STATE_TABLE_WITH_DEADZONE_CORE_ASSERT_SVH
`define GAMEPAD_STATE_TABLE_WITH_DEADZONE_CORE_ASSERT_SVH

// same-cycle implication
`define GSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/gsd_pkg.sv
`default_nettype none

package gsd_pkg;

  localparam int USER_SLOTS_DEF = 4;

  localparam int MODE_W   = 2;
  localparam int USER_W   = 4;
  localparam int BTN_W    = 16;
  localparam int TRIG_W   = 8;
  localparam int AXIS_W   = 16;
  localparam int DZ_W     = 15;
  localparam int TOTAL_W  = 4;
  localparam int PKT_W    = 32;
  localparam int QUO_W    = 16;
  localparam int CNT_W    = $clog2(QUO_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [MODE_W-1:0] MODE_SET_CONN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STORE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ = 1'b1;

  localparam logic [DZ_W-1:0] DZ_LEFT_RST  = 15'd7849;
  localparam logic [DZ_W-1:0] DZ_RIGHT_RST = 15'd8689;
  localparam logic [DZ_W-1:0] AXIS_FULL    = 15'd32767;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [DZ_W-1:0]          dz_t;

endpackage

`default_nettype wire

>>> rtl/core/gsd_if.sv
`default_nettype none

interface gsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [gsd_pkg::MODE_W-1:0]    mode;
  logic [gsd_pkg::USER_W-1:0]    user_index;
  logic                          connect_on;
  logic [gsd_pkg::BTN_W-1:0]     buttons_in;
  logic [gsd_pkg::TRIG_W-1:0]    left_trigger_in;
  logic [gsd_pkg::TRIG_W-1:0]    right_trigger_in;
  gsd_pkg::axis_t                stick_lx_in;
  gsd_pkg::axis_t                stick_ly_in;
  gsd_pkg::axis_t                stick_rx_in;
  gsd_pkg::axis_t                stick_ry_in;

  modport source (
    output valid, mode, user_index, connect_on, buttons_in, left_trigger_in,
           right_trigger_in, stick_lx_in, stick_ly_in, stick_rx_in, stick_ry_in,
    input  ready
  );
  modport sink (
    input  valid, mode, user_index, connect_on, buttons_in, left_trigger_in,
           right_trigger_in, stick_lx_in, stick_ly_in, stick_rx_in, stick_ry_in,
    output ready
  );
endinterface

interface gsd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic                          slot_connected;
  logic [gsd_pkg::TOTAL_W-1:0]   connected_total;
  logic [gsd_pkg::BTN_W-1:0]     buttons_out;
  logic [gsd_pkg::TRIG_W-1:0]    left_trigger_out;
  logic [gsd_pkg::TRIG_W-1:0]    right_trigger_out;
  gsd_pkg::axis_t                stick_lx_out;
  gsd_pkg::axis_t                stick_ly_out;
  gsd_pkg::axis_t                stick_rx_out;
  gsd_pkg::axis_t                stick_ry_out;
  logic [gsd_pkg::PKT_W-1:0]     packet_number;

  modport source (
    output valid, ok, slot_connected, connected_total, buttons_out, left_trigger_out,
           right_trigger_out, stick_lx_out, stick_ly_out, stick_rx_out, stick_ry_out,
           packet_number,
    input  ready
  );
  modport sink (
    input  valid, ok, slot_connected, connected_total, buttons_out, left_trigger_out,
           right_trigger_out, stick_lx_out, stick_ly_out, stick_rx_out, stick_ry_out,
           packet_number,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/gamepad_state_table_with_deadzone_core.sv
// Controller slot table with stick deadzone rescale.
// in_ch carries one command beat (set connection, store report, read back);
// out_ch returns exactly one result beat per command, in order.
// cfg_we/cfg_index/cfg_wdata write the left (index 0) and right (index 1)
// deadzones; write them only while no command is in flight.
// in_ch.ready is high only while the sequencer is idle. A set, store or
// rejected command passes through the execute and done states; its result is
// loaded into the output register from the done state once that register is
// free, and the sequencer then returns to idle for the next beat. A read runs
// each of the four axes through one shared restoring divider, one quotient bit
// per cycle; an axis inside the deadzone or with a full-scale deadzone skips
// the divider, and an early overflow check saturates an axis and ends its loop.
// Reset unplugs every slot, clears all records and counters and restores
// the deadzones to 7849 / 8689. Results sit in an output register: while the
// receiver stalls the next command is still accepted and worked on, and it
// waits at the end for the output register to free up.
`default_nettype none

`include "gamepad_state_table_with_deadzone_core_assert.svh"

module gamepad_state_table_with_deadzone_core #(
  parameter int USER_SLOTS = gsd_pkg::USER_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsd_pkg::DZ_W-1:0]        cfg_wdata,
  gsd_in_if.sink                          in_ch,
  gsd_out_if.source                       out_ch
);

  localparam int SLOT_W   = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int AXIS_W   = gsd_pkg::AXIS_W;
  localparam int STICKS_W = 4 * AXIS_W;
  localparam int TRIGS_W  = 2 * gsd_pkg::TRIG_W;
  localparam int MAG_W    = AXIS_W + 1;
  localparam int DVD_W    = 2 * gsd_pkg::DZ_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_AXIS = 7'b0000100,
    S_LOAD = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_NEXT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  gsd_pkg::dz_t dz_left_r, dz_right_r;

  // slot table
  logic                        plug_r      [USER_SLOTS];
  logic [gsd_pkg::BTN_W-1:0]   btn_tab_r   [USER_SLOTS];
  logic [TRIGS_W-1:0]          trig_tab_r  [USER_SLOTS];
  logic [STICKS_W-1:0]         stick_tab_r [USER_SLOTS];
  logic [gsd_pkg::PKT_W-1:0]   pkt_tab_r   [USER_SLOTS];

  // latched command
  logic [gsd_pkg::MODE_W-1:0]  mode_r;
  logic [gsd_pkg::USER_W-1:0]  user_r;
  logic                        on_r;
  logic [gsd_pkg::BTN_W-1:0]   btn_in_r;
  logic [TRIGS_W-1:0]          trig_in_r;
  logic [STICKS_W-1:0]         stick_in_r;

  // result under construction
  logic                        res_ok_r;
  logic [gsd_pkg::BTN_W-1:0]   res_btn_r;
  logic [TRIGS_W-1:0]          res_trig_r;
  logic [gsd_pkg::PKT_W-1:0]   res_pkt_r;
  gsd_pkg::axis_t              res_axis_r [4];
  logic [STICKS_W-1:0]         stk_r;
  logic [1:0]                  axis_r;

  // divider datapath
  logic                        neg_r, zero_r, sat_r;
  logic [MAG_W-1:0]            num_r;
  gsd_pkg::dz_t                den_r;
  logic [gsd_pkg::DZ_W-1:0]    rem_r, rem_nxt;
  logic [gsd_pkg::QUO_W-1:0]   work_r, work_nxt;
  logic [gsd_pkg::CNT_W-1:0]   cnt_r;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_ok_r, out_conn_r;
  logic [gsd_pkg::TOTAL_W-1:0] out_total_r;
  logic [gsd_pkg::BTN_W-1:0]   out_btn_r;
  logic [TRIGS_W-1:0]          out_trig_r;
  gsd_pkg::axis_t              out_lx_r, out_ly_r, out_rx_r, out_ry_r;
  logic [gsd_pkg::PKT_W-1:0]   out_pkt_r;

  logic [SLOT_W-1:0]           sel;
  logic                        hit, sel_plugged, read_go, out_free, div_ovf;
  logic [gsd_pkg::TOTAL_W-1:0] total;
  logic [AXIS_W-1:0]           cur_v;
  gsd_pkg::dz_t                cur_dz;
  logic [MAG_W-1:0]            ax_mag, ax_num;
  logic                        ax_zero, ax_sat;
  logic [31:0]                 dvd;
  logic [AXIS_W:0]             div_t, div_diff;
  logic                        div_ge;
  logic [MAG_W-1:0]            neg_mag;
  logic [AXIS_W-1:0]           axis_val;
  logic                        store_changed;

  assign sel         = user_r[SLOT_W-1:0];
  assign hit         = int'(user_r) < USER_SLOTS;
  assign sel_plugged = hit && plug_r[sel];
  assign read_go     = sel_plugged && (mode_r == gsd_pkg::MODE_READ);
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    total = '0;
    for (int i = 0; i < USER_SLOTS; i++) begin
      total = total + gsd_pkg::TOTAL_W'(plug_r[i]);
    end
  end

  assign store_changed = (btn_tab_r[sel] != btn_in_r) || (trig_tab_r[sel] != trig_in_r) ||
                         (stick_tab_r[sel] != stick_in_r);

  // per-axis setup: magnitude and distance past the deadzone
  assign cur_v   = stk_r[AXIS_W-1:0];
  assign cur_dz  = axis_r[1] ? dz_right_r : dz_left_r;
  assign ax_mag  = cur_v[AXIS_W-1] ? (MAG_W'(1 << AXIS_W) - {1'b0, cur_v}) : {1'b0, cur_v};
  assign ax_num  = ax_mag - {2'b0, cur_dz};
  assign ax_zero = (ax_mag < {2'b0, cur_dz}) || (ax_num == '0);
  assign ax_sat  = (cur_dz == gsd_pkg::AXIS_FULL);

  // num * 32767 as a shift and subtract; fits in 30 bits
  assign dvd = ({15'b0, num_r} << gsd_pkg::DZ_W) - {15'b0, num_r};

  // quotient bits above 15 mean the result saturates anyway
  assign div_ovf  = (cnt_r == '0) && (rem_r >= den_r);
  assign div_t    = {1'b0, rem_r, work_r[gsd_pkg::QUO_W-1]};
  assign div_ge   = div_t >= {2'b0, den_r};
  assign div_diff = div_t - {2'b0, den_r};
  assign rem_nxt  = div_ge ? div_diff[gsd_pkg::DZ_W-1:0] : div_t[gsd_pkg::DZ_W-1:0];
  assign work_nxt = {work_r[gsd_pkg::QUO_W-2:0], div_ge};

  always_comb begin
    neg_mag  = '0;
    axis_val = '0;
    if (zero_r) begin
      axis_val = '0;
    end else if (neg_r) begin
      neg_mag  = (sat_r || (work_r > 16'h8000)) ? MAG_W'(17'h08000) : {1'b0, work_r};
      axis_val = 16'(MAG_W'(1 << AXIS_W) - neg_mag);
    end else begin
      axis_val = (sat_r || (work_r > 16'h7FFF)) ? 16'h7FFF : work_r;
    end
  end

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = in_ch.valid ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = read_go ? S_AXIS : S_DONE;
      S_AXIS:  state_nxt = (ax_zero || ax_sat) ? S_NEXT : S_LOAD;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV:   state_nxt = (div_ovf || (cnt_r == gsd_pkg::CNT_W'(gsd_pkg::QUO_W - 1))) ?
                           S_NEXT : S_DIV;
      S_NEXT:  state_nxt = (axis_r == 2'd3) ? S_DONE : S_AXIS;
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_left_r  <= gsd_pkg::DZ_LEFT_RST;
      dz_right_r <= gsd_pkg::DZ_RIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gsd_pkg::CFG_LEFT_DZ:  dz_left_r  <= cfg_wdata;
        gsd_pkg::CFG_RIGHT_DZ: dz_right_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < USER_SLOTS; i++) begin
        plug_r[i]      <= 1'b0;
        btn_tab_r[i]   <= '0;
        trig_tab_r[i]  <= '0;
        stick_tab_r[i] <= '0;
        pkt_tab_r[i]   <= '0;
      end
    end else if ((state_r == S_EXEC) && hit) begin
      case (mode_r)
        gsd_pkg::MODE_SET_CONN: begin
          plug_r[sel] <= on_r;
          if (!on_r) begin
            btn_tab_r[sel]   <= '0;
            trig_tab_r[sel]  <= '0;
            stick_tab_r[sel] <= '0;
            pkt_tab_r[sel]   <= '0;
          end
        end
        gsd_pkg::MODE_STORE: begin
          if (plug_r[sel]) begin
            btn_tab_r[sel]   <= btn_in_r;
            trig_tab_r[sel]  <= trig_in_r;
            stick_tab_r[sel] <= stick_in_r;
            if (store_changed) begin
              pkt_tab_r[sel] <= pkt_tab_r[sel] + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_r     <= in_ch.mode;
          user_r     <= in_ch.user_index;
          on_r       <= in_ch.connect_on;
          btn_in_r   <= in_ch.buttons_in;
          trig_in_r  <= {in_ch.right_trigger_in, in_ch.left_trigger_in};
          stick_in_r <= {in_ch.stick_ry_in, in_ch.stick_rx_in,
                         in_ch.stick_ly_in, in_ch.stick_lx_in};
        end
      end
      S_EXEC: begin
        res_ok_r   <= hit && ((mode_r == gsd_pkg::MODE_SET_CONN) ||
                              (plug_r[sel] && ((mode_r == gsd_pkg::MODE_STORE) ||
                                               (mode_r == gsd_pkg::MODE_READ))));
        res_btn_r  <= read_go ? btn_tab_r[sel] : '0;
        res_trig_r <= read_go ? trig_tab_r[sel] : '0;
        res_pkt_r  <= read_go ? pkt_tab_r[sel] : '0;
        stk_r      <= read_go ? stick_tab_r[sel] : '0;
        for (int i = 0; i < 4; i++) begin
          res_axis_r[i] <= '0;
        end
        axis_r <= '0;
      end
      S_AXIS: begin
        neg_r  <= cur_v[AXIS_W-1];
        num_r  <= ax_num;
        den_r  <= gsd_pkg::AXIS_FULL - cur_dz;
        zero_r <= ax_zero;
        sat_r  <= ax_sat;
      end
      S_LOAD: begin
        rem_r  <= {1'b0, dvd[DVD_W-1:gsd_pkg::QUO_W]};
        work_r <= dvd[gsd_pkg::QUO_W-1:0];
        cnt_r  <= '0;
      end
      S_DIV: begin
        if (div_ovf) begin
          sat_r <= 1'b1;
        end else begin
          rem_r  <= rem_nxt;
          work_r <= work_nxt;
          cnt_r  <= cnt_r + 1'b1;
        end
      end
      S_NEXT: begin
        res_axis_r[axis_r] <= axis_val;
        stk_r              <= {{AXIS_W{1'b0}}, stk_r[STICKS_W-1:AXIS_W]};
        axis_r             <= axis_r + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_ok_r    <= res_ok_r;
          out_conn_r  <= sel_plugged;
          out_total_r <= total;
          out_btn_r   <= res_btn_r;
          out_trig_r  <= res_trig_r;
          out_lx_r    <= res_axis_r[0];
          out_ly_r    <= res_axis_r[1];
          out_rx_r    <= res_axis_r[2];
          out_ry_r    <= res_axis_r[3];
          out_pkt_r   <= res_pkt_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.ok                = out_ok_r;
  assign out_ch.slot_connected    = out_conn_r;
  assign out_ch.connected_total   = out_total_r;
  assign out_ch.buttons_out       = out_btn_r;
  assign out_ch.left_trigger_out  = out_trig_r[gsd_pkg::TRIG_W-1:0];
  assign out_ch.right_trigger_out = out_trig_r[TRIGS_W-1:gsd_pkg::TRIG_W];
  assign out_ch.stick_lx_out      = out_lx_r;
  assign out_ch.stick_ly_out      = out_ly_r;
  assign out_ch.stick_rx_out      = out_rx_r;
  assign out_ch.stick_ry_out      = out_ry_r;
  assign out_ch.packet_number     = out_pkt_r;

  `GSD_ASSERT_NXT(a_accept_exec, in_ch.valid && in_ch.ready, state_r == S_EXEC, "accepted beat did not start execution")
  `GSD_ASSERT_IMP(a_load_from_done, out_valid_r && !$past(out_valid_r), $past(state_r) == S_DONE, "result loaded outside done state")
  `GSD_ASSERT_IMP(a_reject_clean, out_valid_r && !out_ok_r, out_pkt_r == '0 && out_btn_r == '0 && out_lx_r == '0 && out_ry_r == '0, "rejected result carries data")
  `GSD_ASSERT_NXT(a_div_exit, state_r == S_DIV, state_r == S_DIV || state_r == S_NEXT, "divider left without finishing axis")
  `GSD_ASSERT_IMP(a_conn_total, out_valid_r && out_conn_r, out_total_r != '0, "connected slot but zero total")

endmodule

`default_nettype wire

>>> tb/tb_gamepad_state_table_with_deadzone_core.sv
module tb_gamepad_state_table_with_deadzone_core;

  localparam int SLOTS = gsd_pkg::USER_SLOTS_DEF;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [gsd_pkg::MODE_W-1:0] MODE_UNDEFINED = 2'd3;
  localparam int RANDOM_PER_PHASE = 125;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTINGS_COUNT = 6;

  typedef struct packed {
    logic [gsd_pkg::MODE_W-1:0] mode;
    logic [gsd_pkg::USER_W-1:0] user;
    logic                       conn;
    logic [gsd_pkg::BTN_W-1:0]  buttons;
    logic [gsd_pkg::TRIG_W-1:0] ltrig;
    logic [gsd_pkg::TRIG_W-1:0] rtrig;
    gsd_pkg::axis_t             lx;
    gsd_pkg::axis_t             ly;
    gsd_pkg::axis_t             rx;
    gsd_pkg::axis_t             ry;
  } slot_command_t;

  typedef struct packed {
    logic [gsd_pkg::BTN_W-1:0]  buttons;
    logic [gsd_pkg::TRIG_W-1:0] ltrig;
    logic [gsd_pkg::TRIG_W-1:0] rtrig;
    gsd_pkg::axis_t             lx;
    gsd_pkg::axis_t             ly;
    gsd_pkg::axis_t             rx;
    gsd_pkg::axis_t             ry;
  } slot_record_t;

  typedef struct packed {
    logic                        ok;
    logic                        slot_conn;
    logic [gsd_pkg::TOTAL_W-1:0] total;
    logic [gsd_pkg::BTN_W-1:0]   buttons;
    logic [gsd_pkg::TRIG_W-1:0]  ltrig;
    logic [gsd_pkg::TRIG_W-1:0]  rtrig;
    gsd_pkg::axis_t              lx;
    gsd_pkg::axis_t              ly;
    gsd_pkg::axis_t              rx;
    gsd_pkg::axis_t              ry;
    logic [gsd_pkg::PKT_W-1:0]   packets;
  } slot_report_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [gsd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gsd_pkg::DZ_W-1:0]      cfg_wdata;

  gsd_in_if  in_ch ();
  gsd_out_if out_ch ();

  gamepad_state_table_with_deadzone_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // slot table as the block should hold it
  logic                      plugged [SLOTS];
  slot_record_t              records [SLOTS];
  logic [gsd_pkg::PKT_W-1:0] packet_count [SLOTS];
  gsd_pkg::dz_t              dz_left;
  gsd_pkg::dz_t              dz_right;

  // last report queued per slot, used to build unchanged stores
  slot_record_t     queued_records [SLOTS];

  slot_command_t pending_commands [$];
  slot_report_t  expected_reports [$];
  int commands_offered;
  int commands_taken;
  int mismatch_count;
  int cycle_count;
  int send_gap;
  int send_calm;
  int sink_stall;
  int sink_calm;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic gsd_pkg::axis_t deadzone_rescale(gsd_pkg::axis_t v, gsd_pkg::dz_t dz);
    logic [31:0] mag;
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] scaled;
    logic [31:0] folded;
    mag = v[gsd_pkg::AXIS_W-1] ? 32'h10000 - {16'h0, v} : {16'h0, v};
    if (mag < {17'h0, dz}) return '0;
    num = mag - {17'h0, dz};
    den = {17'h0, gsd_pkg::AXIS_FULL} - {17'h0, dz};
    if (num == 0) return '0;
    scaled = (den == 0) ? 32'hFFFF_FFFF : (num * 32'd32767) / den;
    if (v[gsd_pkg::AXIS_W-1]) begin
      if (scaled > 32'd32768) scaled = 32'd32768;
      folded = 32'h10000 - scaled;
    end else begin
      if (scaled > 32'd32767) scaled = 32'd32767;
      folded = scaled;
    end
    return folded[gsd_pkg::AXIS_W-1:0];
  endfunction

  function automatic slot_report_t apply_command(slot_command_t c);
    slot_report_t      r;
    slot_record_t      incoming;
    logic              hit;
    logic [SLOT_W-1:0] s;
    int                n;
    r = '0;
    n = 0;
    hit = c.user < SLOTS;
    s = c.user[SLOT_W-1:0];
    incoming = '{c.buttons, c.ltrig, c.rtrig, c.lx, c.ly, c.rx, c.ry};
    if (hit) begin
      case (c.mode)
        gsd_pkg::MODE_SET_CONN: begin
          plugged[s] = c.conn;
          if (!c.conn) begin
            records[s] = '0;
            packet_count[s] = '0;
          end
          r.ok = 1'b1;
        end
        gsd_pkg::MODE_STORE: if (plugged[s]) begin
          if (records[s] != incoming) packet_count[s]++;
          records[s] = incoming;
          r.ok = 1'b1;
        end
        gsd_pkg::MODE_READ: if (plugged[s]) begin
          r.buttons = records[s].buttons;
          r.ltrig   = records[s].ltrig;
          r.rtrig   = records[s].rtrig;
          r.lx      = deadzone_rescale(records[s].lx, dz_left);
          r.ly      = deadzone_rescale(records[s].ly, dz_left);
          r.rx      = deadzone_rescale(records[s].rx, dz_right);
          r.ry      = deadzone_rescale(records[s].ry, dz_right);
          r.packets = packet_count[s];
          r.ok      = 1'b1;
        end
        default: ;
      endcase
    end
    r.slot_conn = hit ? plugged[s] : 1'b0;
    for (int i = 0; i < SLOTS; i++) if (plugged[i]) n++;
    r.total = gsd_pkg::TOTAL_W'(n);
    return r;
  endfunction

  function automatic slot_command_t make_command(logic [gsd_pkg::MODE_W-1:0] mode, int user,
                                                 int conn, int buttons, int ltrig, int rtrig,
                                                 int lx, int ly, int rx, int ry);
    slot_command_t c;
    c.mode = mode;
    c.user = gsd_pkg::USER_W'(user);
    c.conn = conn[0];
    c.buttons = gsd_pkg::BTN_W'(buttons);
    c.ltrig = gsd_pkg::TRIG_W'(ltrig);
    c.rtrig = gsd_pkg::TRIG_W'(rtrig);
    c.lx = gsd_pkg::AXIS_W'(lx);
    c.ly = gsd_pkg::AXIS_W'(ly);
    c.rx = gsd_pkg::AXIS_W'(rx);
    c.ry = gsd_pkg::AXIS_W'(ry);
    return c;
  endfunction

  // axis values weighted toward the full-scale ends and the deadzone edge
  function automatic gsd_pkg::axis_t pick_axis(gsd_pkg::dz_t dz);
    int m;
    gsd_pkg::axis_t v;
    m = int'(dz) + int'($urandom_range(0, 2)) - 1;
    case ($urandom_range(0, 11))
      0: v = 16'sh8000;
      1: v = 16'sh7FFF;
      2: v = '0;
      3: v = 16'sh8001;
      4: v = gsd_pkg::AXIS_W'(m);
      5: v = gsd_pkg::AXIS_W'(-m);
      6: v = ($urandom_range(0, 1) != 0) ? 16'sh0001 : 16'shFFFF;
      default: v = gsd_pkg::AXIS_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic slot_command_t random_command();
    slot_command_t c;
    int pick;
    pick = int'($urandom_range(0, 99));
    c.buttons = gsd_pkg::BTN_W'($urandom);
    c.ltrig = gsd_pkg::TRIG_W'($urandom);
    c.rtrig = gsd_pkg::TRIG_W'($urandom);
    c.lx = pick_axis(dz_left);
    c.ly = pick_axis(dz_left);
    c.rx = pick_axis(dz_right);
    c.ry = pick_axis(dz_right);
    c.conn = ($urandom_range(0, 6) != 0);
    if ($urandom_range(0, 19) == 0) c.user = gsd_pkg::USER_W'($urandom_range(SLOTS, 15));
    else c.user = gsd_pkg::USER_W'($urandom_range(0, SLOTS - 1));
    if (pick < 12) c.mode = gsd_pkg::MODE_SET_CONN;
    else if (pick < 57) c.mode = gsd_pkg::MODE_STORE;
    else if (pick < 96) c.mode = gsd_pkg::MODE_READ;
    else c.mode = MODE_UNDEFINED;
    if (c.mode == gsd_pkg::MODE_STORE && c.user < SLOTS) begin
      case ($urandom_range(0, 9))
        0, 1: {c.buttons, c.ltrig, c.rtrig, c.lx, c.ly, c.rx, c.ry} =
                queued_records[c.user[SLOT_W-1:0]];
        2: begin
          {c.buttons, c.ltrig, c.rtrig, c.lx, c.ly, c.rx, c.ry} =
            queued_records[c.user[SLOT_W-1:0]];
          c.ry = c.ry ^ (16'h1 << $urandom_range(0, 15));
        end
        default: ;
      endcase
      queued_records[c.user[SLOT_W-1:0]] =
        '{c.buttons, c.ltrig, c.rtrig, c.lx, c.ly, c.rx, c.ry};
    end
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 65) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic write_deadzones(gsd_pkg::dz_t left_value, gsd_pkg::dz_t right_value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = gsd_pkg::CFG_LEFT_DZ;
    cfg_wdata = left_value;
    @(negedge clk);
    cfg_index = gsd_pkg::CFG_RIGHT_DZ;
    cfg_wdata = right_value;
    @(negedge clk);
    cfg_we = 1'b0;
    dz_left = left_value;
    dz_right = right_value;
  endtask

  task automatic wait_idle();
    while (pending_commands.size() != 0 || commands_taken != commands_offered ||
           expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: one command beat at a time, random gaps between beats
  always @(negedge clk) begin
    slot_command_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && commands_taken != commands_offered) begin
      // beat still waiting for ready
    end else if (send_gap > 0) begin
      send_gap--;
      in_ch.valid <= 1'b0;
    end else if (pending_commands.size() != 0) begin
      nxt = pending_commands.pop_front();
      in_ch.mode             <= nxt.mode;
      in_ch.user_index       <= nxt.user;
      in_ch.connect_on       <= nxt.conn;
      in_ch.buttons_in       <= nxt.buttons;
      in_ch.left_trigger_in  <= nxt.ltrig;
      in_ch.right_trigger_in <= nxt.rtrig;
      in_ch.stick_lx_in      <= nxt.lx;
      in_ch.stick_ly_in      <= nxt.ly;
      in_ch.stick_rx_in      <= nxt.rx;
      in_ch.stick_ry_in      <= nxt.ry;
      in_ch.valid            <= 1'b1;
      commands_offered++;
      if (send_calm > 0) begin
        send_calm--;
        send_gap = 0;
      end else begin
        send_gap = pick_gap();
        if ($urandom_range(0, 39) == 0) send_calm = int'($urandom_range(20, 80));
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // receiver: random stalls, with runs of full throughput
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (sink_calm > 0) sink_calm--;
      else begin
        sink_stall = pick_gap();
        if ($urandom_range(0, 39) == 0) sink_calm = int'($urandom_range(20, 80));
      end
    end
  end

  always @(posedge clk) begin
    slot_command_t c;
    slot_report_t  want;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tb_gamepad_state_table_with_deadzone_core: FAIL");
        $finish;
      end
      if (in_ch.valid && in_ch.ready) begin
        c.mode    = in_ch.mode;
        c.user    = in_ch.user_index;
        c.conn    = in_ch.connect_on;
        c.buttons = in_ch.buttons_in;
        c.ltrig   = in_ch.left_trigger_in;
        c.rtrig   = in_ch.right_trigger_in;
        c.lx      = in_ch.stick_lx_in;
        c.ly      = in_ch.stick_ly_in;
        c.rx      = in_ch.stick_rx_in;
        c.ry      = in_ch.stick_ry_in;
        expected_reports.push_back(apply_command(c));
        commands_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with nothing expected: expected none, actual ok %0h",
                   $time, out_ch.ok);
        end else begin
          want = expected_reports.pop_front();
          check_field("ok", 32'(want.ok), 32'(out_ch.ok));
          check_field("slot_connected", 32'(want.slot_conn), 32'(out_ch.slot_connected));
          check_field("connected_total", 32'(want.total), 32'(out_ch.connected_total));
          check_field("buttons_out", 32'(want.buttons), 32'(out_ch.buttons_out));
          check_field("left_trigger_out", 32'(want.ltrig), 32'(out_ch.left_trigger_out));
          check_field("right_trigger_out", 32'(want.rtrig), 32'(out_ch.right_trigger_out));
          check_field("stick_lx_out", 32'(want.lx), 32'(out_ch.stick_lx_out));
          check_field("stick_ly_out", 32'(want.ly), 32'(out_ch.stick_ly_out));
          check_field("stick_rx_out", 32'(want.rx), 32'(out_ch.stick_rx_out));
          check_field("stick_ry_out", 32'(want.ry), 32'(out_ch.stick_ry_out));
          check_field("packet_number", want.packets, out_ch.packet_number);
        end
      end
    end
  end

  initial begin
    gsd_pkg::dz_t left_plan [SETTINGS_COUNT];
    gsd_pkg::dz_t right_plan [SETTINGS_COUNT];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = gsd_pkg::CFG_LEFT_DZ;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = gsd_pkg::MODE_SET_CONN;
    in_ch.user_index = '0;
    in_ch.connect_on = 1'b0;
    in_ch.buttons_in = '0;
    in_ch.left_trigger_in = '0;
    in_ch.right_trigger_in = '0;
    in_ch.stick_lx_in = '0;
    in_ch.stick_ly_in = '0;
    in_ch.stick_rx_in = '0;
    in_ch.stick_ry_in = '0;
    out_ch.ready = 1'b0;
    commands_offered = 0;
    commands_taken = 0;
    mismatch_count = 0;
    cycle_count = 0;
    send_gap = 0;
    send_calm = 0;
    sink_stall = 0;
    sink_calm = 0;
    dz_left = gsd_pkg::DZ_LEFT_RST;
    dz_right = gsd_pkg::DZ_RIGHT_RST;
    for (int i = 0; i < SLOTS; i++) begin
      plugged[i] = 1'b0;
      records[i] = '0;
      packet_count[i] = '0;
      queued_records[i] = '0;
    end
    left_plan  = '{15'd0, 15'd32767, 15'd32766, 15'd100, 15'd0, gsd_pkg::DZ_LEFT_RST};
    right_plan = '{15'd32767, 15'd0, 15'd1, 15'd16384, 15'd0, gsd_pkg::DZ_RIGHT_RST};
    left_plan[4] = gsd_pkg::DZ_W'($urandom);
    right_plan[4] = gsd_pkg::DZ_W'($urandom);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // unplugged, undefined mode and out-of-range slots first
    pending_commands.push_back(make_command(gsd_pkg::MODE_READ, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_commands.push_back(make_command(gsd_pkg::MODE_STORE, 0, 1, 16'h1234, 1, 2,
                                            3, 4, 5, 6));
    pending_commands.push_back(make_command(MODE_UNDEFINED, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_commands.push_back(make_command(gsd_pkg::MODE_SET_CONN, 15, 1, 0, 0, 0,
                                            0, 0, 0, 0));
    pending_commands.push_back(make_command(gsd_pkg::MODE_READ, SLOTS, 1, 0, 0, 0,
                                            0, 0, 0, 0));
    for (int i = 0; i < SLOTS; i++)
      pending_commands.push_back(make_command(gsd_pkg::MODE_SET_CONN, i, 1, 0, 0, 0,
                                              0, 0, 0, 0));
    pending_commands.push_back(make_command(gsd_pkg::MODE_STORE, 0, 0, 16'hFFFF, 255, 255,
                                            -32768, 32767, 0, -1));
    // identical report: counter must hold
    pending_commands.push_back(make_command(gsd_pkg::MODE_STORE, 0, 0, 16'hFFFF, 255, 255,
                                            -32768, 32767, 0, -1));
    pending_commands.push_back(make_command(gsd_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // deadzone edge: exactly on it, just inside, just outside
    pending_commands.push_back(make_command(gsd_pkg::MODE_STORE, 3, 0, 0, 0, 0,
                                            7849, -7848, 8690, -32767));
    pending_commands.push_back(make_command(gsd_pkg::MODE_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0));
    // replug keeps the record, unplug clears it
    pending_commands.push_back(make_command(gsd_pkg::MODE_SET_CONN, 0, 1, 0, 0, 0,
                                            0, 0, 0, 0));
    pending_commands.push_back(make_command(gsd_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_commands.push_back(make_command(gsd_pkg::MODE_SET_CONN, 0, 0, 0, 0, 0,
                                            0, 0, 0, 0));
    pending_commands.push_back(make_command(gsd_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_commands.push_back(make_command(gsd_pkg::MODE_SET_CONN, 0, 1, 0, 0, 0,
                                            0, 0, 0, 0));
    pending_commands.push_back(make_command(gsd_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_commands.push_back(make_command(MODE_UNDEFINED, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_commands.push_back(make_command(MODE_UNDEFINED, 9, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_commands.push_back(make_command(gsd_pkg::MODE_STORE, 1, 0, 16'h5555, 16'hAA,
                                            16'h55, 16'h5555, -21846, -12000, 12000));
    pending_commands.push_back(make_command(gsd_pkg::MODE_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    for (int i = 0; i < SLOTS; i++) queued_records[i] = records[i];
    for (int n = 0; n < RANDOM_PER_PHASE; n++) pending_commands.push_back(random_command());
    wait_idle();

    for (int p = 0; p < SETTINGS_COUNT; p++) begin
      write_deadzones(left_plan[p], right_plan[p]);
      // a few reads up front so every stored slot is seen under the new deadzones
      for (int i = 0; i < SLOTS; i++)
        pending_commands.push_back(make_command(gsd_pkg::MODE_READ, i, 0, 0, 0, 0,
                                                0, 0, 0, 0));
      for (int n = 0; n < RANDOM_PER_PHASE; n++) pending_commands.push_back(random_command());
      wait_idle();
    end

    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("tb_gamepad_state_table_with_deadzone_core: PASS");
    end else begin
      $display("tb_gamepad_state_table_with_deadzone_core: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/gsd_pkg.sv
rtl/core/gsd_if.sv
rtl/core/gamepad_state_table_with_deadzone_core.sv
tb/tb_gamepad_state_table_with_deadzone_core.sv
